// ===== sv/websocket_frame_deframer_defines.svh =====
// Assertion macros used by the WebSocket deframer top level.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define WSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define WSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/wsd_pkg.sv =====
// Types, codes and helper functions for the WebSocket frame deframer.
package wsd_pkg;

  // Opcodes that produce results.
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;

  // Frame kind codes on the result side.
  localparam logic [1:0] KIND_TEXT   = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_PING   = 2'd2;
  localparam logic [1:0] KIND_CLOSE  = 2'd3;

  // Short-length escape codes in the second header byte.
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // Extension byte counts for the two escapes.
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Close status used when the close payload is shorter than two bytes.
  localparam logic [15:0] CLOSE_DEFAULT = 16'd1000;

  // One result item.
  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [7:0]  data_byte;
    logic        data_valid;
    logic        last_of_frame;
    logic [15:0] close_code;
    logic        stream_closed;
  } wsd_result_t;

  // Kind lookup: bit 2 says the opcode produces results, bits 1:0 give the kind.
  function automatic logic [2:0] kind_of(input logic [3:0] op);
    logic [2:0] r;
    case (op)
      OP_TEXT:   r = {1'b1, KIND_TEXT};
      OP_BINARY: r = {1'b1, KIND_BINARY};
      OP_PING:   r = {1'b1, KIND_PING};
      OP_CLOSE:  r = {1'b1, KIND_CLOSE};
      default:   r = 3'b000;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/wsd_parser.sv =====
// Frame header parser, payload unmasking and close-code capture.
module wsd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output logic                 res_valid_o,
  output wsd_pkg::wsd_result_t res_o
);
  import wsd_pkg::*;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [3:0]  ext_left_q, ext_left_d;
  logic [63:0] remaining_q, remaining_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  mpos_q, mpos_d;
  logic [1:0]  close_seen_q, close_seen_d;
  logic [15:0] close_val_q, close_val_d;
  logic        closed_q, closed_d;

  logic        len_done, len_mask;
  logic        hdr_done;
  logic [63:0] hdr_rem;
  logic        emit;
  logic [7:0]  e_data;
  logic        e_dvalid, e_last;
  logic [7:0]  key_byte;
  logic [7:0]  plain;
  logic [2:0]  kind_info;
  logic        is_close_end;

  // Mask key byte for the current payload position, first key byte first.
  always_comb begin
    case (mpos_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  assign plain = byte_i ^ key_byte;

  // Next-state logic for one received byte.
  always_comb begin
    phase_d      = phase_q;
    opcode_d     = opcode_q;
    masked_d     = masked_q;
    ext_left_d   = ext_left_q;
    remaining_d  = remaining_q;
    key_d        = key_q;
    mpos_d       = mpos_q;
    close_seen_d = close_seen_q;
    close_val_d  = close_val_q;
    len_done     = 1'b0;
    len_mask     = masked_q;
    hdr_done     = 1'b0;
    hdr_rem      = remaining_q;
    emit         = 1'b0;
    e_data       = 8'd0;
    e_dvalid     = 1'b0;
    e_last       = 1'b0;

    if (step_i && !closed_q) begin
      case (phase_q)
        PH_HDR0: begin
          opcode_d     = byte_i[3:0];
          close_seen_d = 2'd0;
          close_val_d  = CLOSE_DEFAULT;
          phase_d      = PH_HDR1;
        end
        PH_HDR1: begin
          masked_d    = byte_i[7];
          len_mask    = byte_i[7];
          remaining_d = 64'd0;
          if (byte_i[6:0] == LEN_EXT16) begin
            ext_left_d = EXT16_BYTES;
            phase_d    = PH_EXT;
          end else if (byte_i[6:0] == LEN_EXT64) begin
            ext_left_d = EXT64_BYTES;
            phase_d    = PH_EXT;
          end else begin
            remaining_d = {57'd0, byte_i[6:0]};
            len_done    = 1'b1;
          end
        end
        PH_EXT: begin
          remaining_d = {remaining_q[55:0], byte_i};
          ext_left_d  = ext_left_q - 4'd1;
          len_done    = (ext_left_d == 4'd0);
        end
        PH_KEY: begin
          key_d    = {key_q[23:0], byte_i};
          mpos_d   = mpos_q + 2'd1;
          hdr_done = (mpos_d == 2'd0);
        end
        PH_DATA: begin
          mpos_d = mpos_q + 2'd1;
          if (close_seen_q == 2'd0) begin
            close_val_d  = {plain, 8'd0};
            close_seen_d = 2'd1;
          end else if (close_seen_q == 2'd1) begin
            close_val_d  = {close_val_q[15:8], plain};
            close_seen_d = 2'd2;
          end
          remaining_d = remaining_q - 64'd1;
          emit        = 1'b1;
          e_data      = plain;
          e_dvalid    = 1'b1;
          e_last      = (remaining_q == 64'd1);
          if (e_last) begin
            phase_d = PH_HDR0;
          end
        end
        default: begin
          phase_d = PH_HDR0;
        end
      endcase

      // Length known: collect the mask key or finish the header.
      if (len_done) begin
        key_d = 32'd0;
        if (len_mask) begin
          phase_d = PH_KEY;
          mpos_d  = 2'd0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      // Header complete: start the payload or close out an empty frame.
      if (hdr_done) begin
        hdr_rem = remaining_d;
        if (hdr_rem != 64'd0) begin
          phase_d = PH_DATA;
          mpos_d  = 2'd0;
        end else begin
          phase_d = PH_HDR0;
          emit    = 1'b1;
          e_last  = 1'b1;
        end
      end
    end
  end

  // Result assembly; the last result of a close frame ends the stream.
  assign kind_info    = kind_of(opcode_q);
  assign res_valid_o  = emit && kind_info[2];
  assign is_close_end = e_last && (opcode_q == OP_CLOSE);
  assign closed_d     = closed_q || (res_valid_o && is_close_end);

  always_comb begin
    res_o.frame_kind    = kind_info[1:0];
    res_o.data_byte     = e_data;
    res_o.data_valid    = e_dvalid;
    res_o.last_of_frame = e_last;
    res_o.close_code    = 16'd0;
    res_o.stream_closed = 1'b0;
    if (is_close_end) begin
      res_o.close_code    = (close_seen_d == 2'd2) ? close_val_d : CLOSE_DEFAULT;
      res_o.stream_closed = 1'b1;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      opcode_q     <= 4'd0;
      masked_q     <= 1'b0;
      ext_left_q   <= 4'd0;
      remaining_q  <= 64'd0;
      key_q        <= 32'd0;
      mpos_q       <= 2'd0;
      close_seen_q <= 2'd0;
      close_val_q  <= CLOSE_DEFAULT;
      closed_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      opcode_q     <= opcode_d;
      masked_q     <= masked_d;
      ext_left_q   <= ext_left_d;
      remaining_q  <= remaining_d;
      key_q        <= key_d;
      mpos_q       <= mpos_d;
      close_seen_q <= close_seen_d;
      close_val_q  <= close_val_d;
      closed_q     <= closed_d;
    end
  end

endmodule

// ===== sv/wsd_out_reg.sv =====
// Result register with a valid/stall handshake toward the consumer.
module wsd_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  logic                 load_valid_i,
  input  wsd_pkg::wsd_result_t load_res_i,
  input  logic                 out_stall_i,
  output logic                 can_take_o,
  output logic                 out_valid_o,
  output wsd_pkg::wsd_result_t out_res_o
);
  import wsd_pkg::*;

  logic        valid_q, valid_d;
  wsd_result_t res_q;

  // The register may be written when empty or when its request leaves now.
  assign can_take_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (can_take_o) begin
      valid_d = load_i && load_valid_i;
    end
  end

  // Valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload holds while stalled.
  always_ff @(posedge clk_i) begin
    if (can_take_o && load_i && load_valid_i) begin
      res_q <= load_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== sv/websocket_frame_deframer.sv =====
// Top level of the WebSocket receive-side frame deframer.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+-----------------------------------------
//   in      | consumer  | in_valid_i/in_stall_o  | rx_byte_i
//   out     | producer  | out_valid_o/out_stall_i| frame_kind_o data_byte_o data_valid_o
//           |           |                       | last_of_frame_o close_code_o stream_closed_o
//
// One request per cycle in each direction while no stall holds it; a byte that is taken
// passes the input register, then the single parser stage, into the result register.
// Reset is asynchronous and active low; no clearing pass, the block is ready at once.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall_o in the same cycle.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  frame_kind_o,
  output logic [7:0]  data_byte_o,
  output logic        data_valid_o,
  output logic        last_of_frame_o,
  output logic [15:0] close_code_o,
  output logic        stream_closed_o
);
  import wsd_pkg::*;
  `include "websocket_frame_deframer_defines.svh"

  logic        in_valid_q;
  logic [7:0]  rx_byte_q;
  logic        accept;
  logic        step;
  logic        can_take;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t out_res;

  // Input register: a held byte moves on when the result register can take it.
  assign step       = in_valid_q && can_take;
  assign in_stall_o = in_valid_q && !can_take;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_byte_q <= rx_byte_i;
    end
  end

  // Parser stage.
  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (rx_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  wsd_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (step),
    .load_valid_i (res_valid),
    .load_res_i   (res),
    .out_stall_i  (out_stall_i),
    .can_take_o   (can_take),
    .out_valid_o  (out_valid_o),
    .out_res_o    (out_res)
  );

  assign frame_kind_o    = out_res.frame_kind;
  assign data_byte_o     = out_res.data_byte;
  assign data_valid_o    = out_res.data_valid;
  assign last_of_frame_o = out_res.last_of_frame;
  assign close_code_o    = out_res.close_code;
  assign stream_closed_o = out_res.stream_closed;

  // An end-of-stream request is always the last request of a close frame.
  `WSD_ASSERT_NOW(a_close_end_is_last, out_valid_o && stream_closed_o, last_of_frame_o && (frame_kind_o == KIND_CLOSE), "stream closed on a non-final or non-close request")

  // An empty-frame marker always ends its frame.
  `WSD_ASSERT_NOW(a_marker_is_last, out_valid_o && !data_valid_o, last_of_frame_o, "empty-frame marker without last flag")

  // Nothing follows once the closing request has been delivered.
  `WSD_ASSERT_NEXT(a_silent_after_close, out_valid_o && !out_stall_i && stream_closed_o, !out_valid_o, "request produced after stream close")

endmodule

// ===== tb/websocket_frame_deframer_tb.sv =====
// Self-checking testbench for the WebSocket frame deframer, with a byte-level frame predictor.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  // Parser phases of the predictor.
  typedef enum logic [2:0] {PH_HDR0, PH_HDR1, PH_EXT, PH_KEY, PH_DATA} parse_phase_e;

  // One directed row: the byte, and optionally the result typed in by hand.
  typedef struct packed {
    logic [7:0]  rx;
    logic        typed;
    logic        has_res;
    wsd_result_t res;
  } stim_row_t;

  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned HOLD_AFTER   = 400;
  localparam int unsigned HOLD_CYCLES  = 250;

  localparam wsd_result_t NO_RESULT   = '0;
  localparam wsd_result_t TEXT_MARKER = '{KIND_TEXT, 8'h00, 1'b0, 1'b1, 16'd0, 1'b0};
  localparam wsd_result_t BIN_FF_LAST = '{KIND_BINARY, 8'hFF, 1'b1, 1'b1, 16'd0, 1'b0};
  localparam wsd_result_t BIN_5A_LAST = '{KIND_BINARY, 8'h5A, 1'b1, 1'b1, 16'd0, 1'b0};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  frame_kind_o;
  logic [7:0]  data_byte_o;
  logic        data_valid_o;
  logic        last_of_frame_o;
  logic [15:0] close_code_o;
  logic        stream_closed_o;

  // Results still owed by the block, oldest first.
  wsd_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned bytes_accepted = 0;
  bit          steady = 1'b0;

  // Predictor state.
  parse_phase_e phase = PH_HDR0;
  logic [3:0]   cur_opcode = '0;
  logic         masked = 1'b0;
  logic [3:0]   ext_left = '0;
  logic [63:0]  len_left = '0;
  logic [31:0]  key = '0;
  logic [1:0]   key_pos = '0;
  logic [1:0]   close_seen = '0;
  logic [15:0]  close_val = CLOSE_DEFAULT;
  logic         closed = 1'b0;

  // Directed frames: empty text, one-byte binary, masked ping, masked empty pong,
  // reserved opcode with RSV bits, and a non-minimal 16-bit length.
  stim_row_t directed_rows [0:25] = '{
    '{8'h81, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b1, TEXT_MARKER},
    '{8'h82, 1'b1, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, 1'b0, NO_RESULT},
    '{8'hFF, 1'b1, 1'b1, BIN_FF_LAST},
    '{8'h89, 1'b0, 1'b0, NO_RESULT},
    '{8'h81, 1'b0, 1'b0, NO_RESULT},
    '{8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'hAA, 1'b0, 1'b0, NO_RESULT},
    '{8'h55, 1'b0, 1'b0, NO_RESULT},
    '{8'h00, 1'b0, 1'b0, NO_RESULT},
    '{8'h8A, 1'b1, 1'b0, NO_RESULT},
    '{8'h80, 1'b1, 1'b0, NO_RESULT},
    '{8'h12, 1'b1, 1'b0, NO_RESULT},
    '{8'h34, 1'b1, 1'b0, NO_RESULT},
    '{8'h56, 1'b1, 1'b0, NO_RESULT},
    '{8'h78, 1'b1, 1'b0, NO_RESULT},
    '{8'h73, 1'b1, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, 1'b0, NO_RESULT},
    '{8'hAB, 1'b1, 1'b0, NO_RESULT},
    '{8'h02, 1'b1, 1'b0, NO_RESULT},
    '{8'h7E, 1'b1, 1'b0, NO_RESULT},
    '{8'h00, 1'b1, 1'b0, NO_RESULT},
    '{8'h01, 1'b1, 1'b0, NO_RESULT},
    '{8'h5A, 1'b1, 1'b1, BIN_5A_LAST}
  };

  websocket_frame_deframer dut (.*);

  // Clock, period 20 ns.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Builds a result for the current opcode; a close frame ends the stream on its last result.
  function automatic bit frame_result(input logic [7:0] d, input logic dv, input logic last,
                                      output wsd_result_t r);
    r = '0;
    case (cur_opcode)
      OP_TEXT:   r.frame_kind = KIND_TEXT;
      OP_BINARY: r.frame_kind = KIND_BINARY;
      OP_PING:   r.frame_kind = KIND_PING;
      OP_CLOSE:  r.frame_kind = KIND_CLOSE;
      default:   return 1'b0;
    endcase
    r.data_byte = d;
    r.data_valid = dv;
    r.last_of_frame = last;
    if (last && cur_opcode == OP_CLOSE) begin
      r.close_code = (close_seen >= 2'd2) ? close_val : CLOSE_DEFAULT;
      r.stream_closed = 1'b1;
      closed = 1'b1;
    end
    return 1'b1;
  endfunction

  // Advances the frame parser by one byte; returns 1 when the byte yields a result.
  function automatic bit deframe_byte(input logic [7:0] b, output wsd_result_t r);
    logic [7:0] d;
    bit len_known;
    bit hdr_done;
    r = '0;
    len_known = 1'b0;
    hdr_done = 1'b0;
    if (closed) return 1'b0;
    case (phase)
      PH_HDR0: begin
        cur_opcode = b[3:0];
        close_seen = 2'd0;
        close_val = CLOSE_DEFAULT;
        phase = PH_HDR1;
      end
      PH_HDR1: begin
        masked = b[7];
        len_left = '0;
        if (b[6:0] == LEN_EXT16) begin
          ext_left = EXT16_BYTES;
          phase = PH_EXT;
        end else if (b[6:0] == LEN_EXT64) begin
          ext_left = EXT64_BYTES;
          phase = PH_EXT;
        end else begin
          len_left = 64'(b[6:0]);
          len_known = 1'b1;
        end
      end
      PH_EXT: begin
        len_left = {len_left[55:0], b};
        ext_left = ext_left - 4'd1;
        len_known = (ext_left == 4'd0);
      end
      PH_KEY: begin
        key = {key[23:0], b};
        key_pos = key_pos + 2'd1;
        hdr_done = (key_pos == 2'd0);
      end
      PH_DATA: begin
        d = b ^ key[31 - 8*key_pos -: 8];
        key_pos = key_pos + 2'd1;
        // The first two payload bytes form the close status.
        if (close_seen == 2'd0) begin
          close_val = {d, 8'h00};
          close_seen = 2'd1;
        end else if (close_seen == 2'd1) begin
          close_val[7:0] = d;
          close_seen = 2'd2;
        end
        len_left = len_left - 64'd1;
        if (len_left == 64'd0) phase = PH_HDR0;
        return frame_result(d, 1'b1, len_left == 64'd0, r);
      end
      default: begin
        phase = PH_HDR0;
      end
    endcase
    // The length is complete: a masked frame still has its key to read.
    if (len_known) begin
      key = '0;
      if (masked) begin
        phase = PH_KEY;
        key_pos = 2'd0;
      end else begin
        hdr_done = 1'b1;
      end
    end
    // Header complete: start the payload or mark an empty frame.
    if (hdr_done) begin
      if (len_left != 64'd0) begin
        phase = PH_DATA;
        key_pos = 2'd0;
        return 1'b0;
      end
      phase = PH_HDR0;
      return frame_result(8'h00, 1'b0, 1'b1, r);
    end
    return 1'b0;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one byte, waits for the request to be taken, then records what it should yield.
  task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_has,
                           input wsd_result_t typed_res);
    int unsigned gap;
    bit got;
    wsd_result_t r;
    gap = steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = deframe_byte(b, r);
    if (typed) begin
      got = typed_has;
      r = typed_res;
    end
    if (got) pending_results = {pending_results, r};
    bytes_accepted++;
  endtask

  // Sends one well-formed frame with random opcode, flags, length form, key and payload.
  task automatic send_frame(input bit closing);
    logic [3:0] op;
    logic [7:0] hdr0;
    logic [63:0] len64;
    logic [31:0] mkey;
    bit mask;
    int unsigned len;
    int unsigned r;
    int n_ext;
    r = $urandom_range(0, 99);
    if (closing) begin
      op = OP_CLOSE;
    end else if (r < 30) begin
      op = OP_TEXT;
    end else if (r < 58) begin
      op = OP_BINARY;
    end else if (r < 76) begin
      op = OP_PING;
    end else begin
      op = 4'($urandom);
      if (op == OP_CLOSE) op = 4'h0;
    end
    hdr0 = {4'($urandom), op};
    mask = 1'($urandom);
    mkey = $urandom;
    r = $urandom_range(0, 99);
    n_ext = 0;
    if (r < 8) begin
      len = 0;
    end else if (r < 70) begin
      len = $urandom_range(1, 16);
    end else if (r < 80) begin
      len = $urandom_range(17, 125);
    end else if (r < 91) begin
      len = $urandom_range(0, 140);
      n_ext = 2;
    end else begin
      len = $urandom_range(0, 130);
      n_ext = 8;
    end
    // A close frame stays short so that the status code cases all come up.
    if (closing) len = $urandom_range(0, 6);
    len64 = 64'(len);
    send_byte(hdr0, 1'b0, 1'b0, NO_RESULT);
    if (n_ext == 2) begin
      send_byte({mask, LEN_EXT16}, 1'b0, 1'b0, NO_RESULT);
    end else if (n_ext == 8) begin
      send_byte({mask, LEN_EXT64}, 1'b0, 1'b0, NO_RESULT);
    end else begin
      send_byte({mask, 7'(len)}, 1'b0, 1'b0, NO_RESULT);
    end
    for (int i = n_ext - 1; i >= 0; i--) send_byte(len64[8*i +: 8], 1'b0, 1'b0, NO_RESULT);
    if (mask) begin
      for (int i = 3; i >= 0; i--) send_byte(mkey[8*i +: 8], 1'b0, 1'b0, NO_RESULT);
    end
    repeat (len) send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
  endtask

  // Stops offering bytes until every owed result has come out.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Reports one field mismatch.
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compares every accepted result with the oldest owed one.
  always @(posedge clk_i) begin : result_check
    wsd_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with none outstanding: kind %0d data %0h", frame_kind_o, data_byte_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("frame_kind", want.frame_kind, frame_kind_o);
        check_field("data_byte", want.data_byte, data_byte_o);
        check_field("data_valid", want.data_valid, data_valid_o);
        check_field("last_of_frame", want.last_of_frame, last_of_frame_o);
        check_field("close_code", want.close_code, close_code_o);
        check_field("stream_closed", want.stream_closed, stream_closed_o);
      end
    end
  end

  // Result-side stall: random bursts, one long hold-off while bytes keep coming.
  initial begin : result_stall
    bit held;
    bit stall_val;
    int unsigned n;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && bytes_accepted >= HOLD_AFTER) begin
        held = 1'b1;
        stall_val = 1'b1;
        n = HOLD_CYCLES;
      end else if (steady) begin
        stall_val = 1'b0;
        n = 1;
      end else begin
        stall_val = ($urandom_range(0, 2) == 0);
        n = stall_val ? 1 + idle_len() : $urandom_range(1, 8);
      end
      out_stall_i <= stall_val;
      repeat (n) @(posedge clk_i);
    end
  end

  // Reset, directed frames, random frames, a closing frame, then bytes that must be ignored.
  initial begin : stimulus
    int unsigned frames;
    frames = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].has_res,
                directed_rows[i].res);
    end
    drain_results();
    while (bytes_accepted < RANDOM_BYTES) begin
      steady = ($urandom_range(0, 5) == 0);
      send_frame(1'b0);
      frames++;
      // Pause only before the long hold-off, so that the hold-off meets a busy sender.
      if (frames == 15 && bytes_accepted < HOLD_AFTER) drain_results();
    end
    steady = 1'b0;
    send_frame(1'b1);
    repeat (6) send_byte(8'($urandom), 1'b0, 1'b0, NO_RESULT);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: ends a run that hangs.
  initial begin : watchdog
    #12_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
